### hw/rtl/tabb_pkg.sv
// Shared types and constants of the transformed bounding box builder.
package tabb_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned AXES        = 3;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned ROW_W       = 48;
	localparam int unsigned COEF_W      = 16;
	localparam int unsigned FIX_W       = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_X   = 3'd0,
		CFG_ROW_Y   = 3'd1,
		CFG_ROW_Z   = 3'd2,
		CFG_SHIFT_X = 3'd3,
		CFG_SHIFT_Y = 3'd4,
		CFG_SHIFT_Z = 3'd5
	} cfg_reg_t;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
		logic               last;
		logic signed [31:0] other_min_x;
		logic signed [31:0] other_max_x;
		logic signed [31:0] other_min_y;
		logic signed [31:0] other_max_y;
		logic signed [31:0] other_min_z;
		logic signed [31:0] other_max_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_z;
		logic               overlap;
		logic               box_valid;
	} result_t;

	// products indexed 3*axis+input; bounds indexed 2*axis (min), 2*axis+1 (max)
	typedef struct packed {
		logic                              kind;
		logic                              last;
		logic [AXES*AXES-1:0][FIX_W-1:0]   prod;
		logic [2*AXES-1:0][FIX_W-1:0]      other;
	} job_t;

	typedef struct packed {
		logic                              kind;
		logic                              last;
		logic [AXES-1:0][FIX_W-1:0]        point;
		logic [2*AXES-1:0][FIX_W-1:0]      other;
	} point_item_t;

endpackage

### hw/rtl/tabb_front.sv
// Front end: accept input beats and form the nine coefficient products.
module tabb_front (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            item_valid,
	output logic                                            item_stall,
	input  tabb_pkg::item_t                                 item,
	input  logic [tabb_pkg::AXES-1:0][tabb_pkg::ROW_W-1:0]  rows,
	output logic                                            job_valid,
	input  logic                                            job_ready,
	output tabb_pkg::job_t                                  job
);

	logic           job_valid_s1;
	tabb_pkg::job_t job_s1;
	tabb_pkg::job_t job_next;
	logic [tabb_pkg::AXES-1:0][tabb_pkg::COEF_W-1:0] vtx;

	assign item_stall = job_valid_s1 && !job_ready;
	assign job_valid  = job_valid_s1;
	assign job        = job_s1;

	assign vtx = {item.vertex_z, item.vertex_y, item.vertex_x};

	always_comb begin
		job_next.kind = item.kind;
		job_next.last = item.last;
		for (int a = 0; a < tabb_pkg::AXES; a++) begin
			for (int k = 0; k < tabb_pkg::AXES; k++) begin
				job_next.prod[3*a+k] = tabb_pkg::FIX_W'($signed(rows[a][16*k +: 16]))
					* tabb_pkg::FIX_W'($signed(vtx[k]));
			end
		end
		job_next.other = {item.other_max_z, item.other_min_z,
			item.other_max_y, item.other_min_y,
			item.other_max_x, item.other_min_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			job_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			job_s1 <= job_next;
		end
	end

endmodule

### hw/rtl/tabb_queue.sv
// Short queue between front and back ends.
module tabb_queue #(
	parameter int unsigned Depth = tabb_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tabb_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tabb_pkg::job_t pop_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	tabb_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/tabb_back.sv
// Back end: round and translate, fold bounds, commit box, test overlap.
module tabb_back (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           job_valid,
	output logic                                           job_ready,
	input  tabb_pkg::job_t                                 job,
	input  logic [tabb_pkg::AXES-1:0][tabb_pkg::FIX_W-1:0] shifts,
	output logic                                           result_valid,
	input  logic                                           result_stall,
	output tabb_pkg::result_t                              result
);

	localparam int unsigned SumW = tabb_pkg::FIX_W + 2;
	localparam int unsigned NB   = 2 * tabb_pkg::AXES;

	tabb_pkg::point_item_t pt_next;
	tabb_pkg::point_item_t pt_s2;
	logic                  pt_valid_s2;

	logic [NB-1:0][tabb_pkg::FIX_W-1:0] run_q;
	logic [NB-1:0][tabb_pkg::FIX_W-1:0] com_q;
	logic [NB-1:0][tabb_pkg::FIX_W-1:0] fold;
	logic                               first_q;
	logic                               cval_q;

	logic              out_free;
	logic              needs_out;
	logic              pt_fire;
	logic              ok;
	tabb_pkg::result_t res_next;
	logic              result_valid_q;
	tabb_pkg::result_t result_q;

	// round, translate and saturate each axis
	always_comb begin
		logic signed [SumW-1:0] sum;
		logic signed [SumW-1:0] tot;
		pt_next.kind  = job.kind;
		pt_next.last  = job.last;
		pt_next.other = job.other;
		for (int a = 0; a < tabb_pkg::AXES; a++) begin
			sum = SumW'($signed(job.prod[3*a])) + SumW'($signed(job.prod[3*a+1]))
				+ SumW'($signed(job.prod[3*a+2])) + SumW'(2048);
			tot = (sum >>> 12) + SumW'($signed(shifts[a]));
			if (tot[SumW-1:tabb_pkg::FIX_W-1] == '0
				|| tot[SumW-1:tabb_pkg::FIX_W-1] == '1) begin
				pt_next.point[a] = tot[tabb_pkg::FIX_W-1:0];
			end else if (tot[SumW-1]) begin
				pt_next.point[a] = {1'b1, {(tabb_pkg::FIX_W-1){1'b0}}};
			end else begin
				pt_next.point[a] = {1'b0, {(tabb_pkg::FIX_W-1){1'b1}}};
			end
		end
	end

	assign out_free  = !result_valid_q || !result_stall;
	assign needs_out = (pt_s2.kind == tabb_pkg::KIND_QUERY) || pt_s2.last;
	assign pt_fire   = pt_valid_s2 && (!needs_out || out_free);
	assign job_ready = !pt_valid_s2 || pt_fire;

	// fold the point into the running bounds and test the stored box
	always_comb begin
		logic signed [tabb_pkg::FIX_W-1:0] p;
		ok = 1'b1;
		for (int a = 0; a < tabb_pkg::AXES; a++) begin
			p = $signed(pt_s2.point[a]);
			fold[2*a]   = (first_q || p < $signed(run_q[2*a])) ? p : run_q[2*a];
			fold[2*a+1] = (first_q || p > $signed(run_q[2*a+1])) ? p : run_q[2*a+1];
			if (!($signed(pt_s2.other[2*a]) <= $signed(com_q[2*a+1])
				&& $signed(pt_s2.other[2*a+1]) >= $signed(com_q[2*a]))) begin
				ok = 1'b0;
			end
		end
	end

	always_comb begin
		logic [NB-1:0][tabb_pkg::FIX_W-1:0] box;
		if (pt_s2.kind == tabb_pkg::KIND_VERTEX) begin
			box               = fold;
			res_next.overlap  = 1'b0;
			res_next.box_valid = 1'b1;
		end else begin
			box               = cval_q ? com_q : '0;
			res_next.overlap  = cval_q && ok;
			res_next.box_valid = cval_q;
		end
		res_next.box_min_x = box[0];
		res_next.box_max_x = box[1];
		res_next.box_min_y = box[2];
		res_next.box_max_y = box[3];
		res_next.box_min_z = box[4];
		res_next.box_max_z = box[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_valid_s2    <= 1'b0;
			first_q        <= 1'b1;
			cval_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (job_ready) begin
				pt_valid_s2 <= job_valid;
			end
			if (out_free) begin
				result_valid_q <= pt_fire && needs_out;
			end
			if (pt_fire && pt_s2.kind == tabb_pkg::KIND_VERTEX) begin
				first_q <= pt_s2.last;
				if (pt_s2.last) begin
					cval_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			pt_s2 <= pt_next;
		end
		if (pt_fire && pt_s2.kind == tabb_pkg::KIND_VERTEX) begin
			run_q <= fold;
			if (pt_s2.last) begin
				com_q <= fold;
			end
		end
		if (pt_fire && needs_out) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

### hw/rtl/transformed_aabb_builder_unit.sv
// Top level of the transformed bounding box builder with overlap test.
//
// Item channel (item_valid/item_stall/item): a vertex beat (kind 0) is
// transformed by the configured 3x3 Q4.12 matrix and Q24.8 translation and
// folded into the running box; a vertex with last set commits the box and
// returns it. A query beat (kind 1) returns the stored box and whether the
// query box overlaps it on all three axes. Non-last vertices return nothing.
// Result channel (result_valid/result_stall/result): one beat per query or
// last vertex, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no item is in flight. Indexes above 5 are ignored.
// Items are registered in the product stage, queue, back stage and output
// register. Throughput: one item per cycle unless stalled, set by the product
// stage and the combinational bounds fold. A four-entry queue separates the
// product stage from the back end, so a stalled receiver fills the output
// register, the back stage, the queue and the product register, and then
// raises item_stall; non-last vertices still drain while the output waits.
// Reset clears all handshakes, loads the identity matrix and zero
// translation, and marks no box committed.
module transformed_aabb_builder_unit #(
	parameter int unsigned QueueDepth = tabb_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  tabb_pkg::item_t                  item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output tabb_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tabb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tabb_pkg::ROW_W-1:0]       cfg_data
);

	logic [tabb_pkg::AXES-1:0][tabb_pkg::ROW_W-1:0] rows_q;
	logic [tabb_pkg::AXES-1:0][tabb_pkg::FIX_W-1:0] shifts_q;

	logic           fe_valid;
	logic           fe_ready;
	tabb_pkg::job_t fe_job;
	logic           be_valid;
	logic           be_ready;
	tabb_pkg::job_t be_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= tabb_pkg::ROW_X_RESET;
			rows_q[1] <= tabb_pkg::ROW_Y_RESET;
			rows_q[2] <= tabb_pkg::ROW_Z_RESET;
			shifts_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tabb_pkg::CFG_ROW_X:   rows_q[0]   <= cfg_data;
				tabb_pkg::CFG_ROW_Y:   rows_q[1]   <= cfg_data;
				tabb_pkg::CFG_ROW_Z:   rows_q[2]   <= cfg_data;
				tabb_pkg::CFG_SHIFT_X: shifts_q[0] <= cfg_data[tabb_pkg::FIX_W-1:0];
				tabb_pkg::CFG_SHIFT_Y: shifts_q[1] <= cfg_data[tabb_pkg::FIX_W-1:0];
				tabb_pkg::CFG_SHIFT_Z: shifts_q[2] <= cfg_data[tabb_pkg::FIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tabb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.rows       (rows_q),
		.job_valid  (fe_valid),
		.job_ready  (fe_ready),
		.job        (fe_job)
	);

	tabb_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_data  (fe_job),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_data   (be_job)
	);

	tabb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (be_valid),
		.job_ready    (be_ready),
		.job          (be_job),
		.shifts       (shifts_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### test/tabb_box_checker.sv
// Checker for the bounding box builder: predicts each result beat and compares it.
module tabb_box_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  tabb_pkg::item_t                  item,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  tabb_pkg::result_t                result,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [tabb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tabb_pkg::ROW_W-1:0]       cfg_data,
	output int                               errors,
	output int                               pending
);

	logic [tabb_pkg::ROW_W-1:0]        coef_row [tabb_pkg::AXES];
	logic signed [tabb_pkg::FIX_W-1:0] offset [tabb_pkg::AXES];
	logic signed [31:0]                live_box [2*tabb_pkg::AXES];
	logic signed [31:0]                kept_box [2*tabb_pkg::AXES];
	logic                              model_empty;
	logic                              kept_ok;
	tabb_pkg::result_t                 box_answers [$];

	function automatic logic signed [31:0] map_axis(int a, tabb_pkg::item_t it);
		longint pos [3];
		longint acc;
		pos[0] = longint'(it.vertex_x);
		pos[1] = longint'(it.vertex_y);
		pos[2] = longint'(it.vertex_z);
		acc = 0;
		for (int k = 0; k < 3; k++)
			acc += longint'($signed(coef_row[a][16*k +: 16])) * pos[k];
		acc = ((acc + 2048) >>> 12) + longint'(offset[a]);
		if (acc > 64'sd2147483647)
			return 32'sh7fffffff;
		if (acc < -64'sd2147483648)
			return 32'sh80000000;
		return acc[31:0];
	endfunction

	task automatic note_field(string name, logic [31:0] got, logic [31:0] want_v);
		if (got !== want_v) begin
			errors++;
			if (errors <= 10)
				$display("%0t mismatch %s: expected %h, got %h", $realtime, name, want_v, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tabb_pkg::result_t want;
		logic signed [31:0] p;
		if (!arst_n) begin
			coef_row[0] = tabb_pkg::ROW_X_RESET;
			coef_row[1] = tabb_pkg::ROW_Y_RESET;
			coef_row[2] = tabb_pkg::ROW_Z_RESET;
			for (int a = 0; a < tabb_pkg::AXES; a++)
				offset[a] = '0;
			for (int i = 0; i < 2*tabb_pkg::AXES; i++) begin
				live_box[i] = '0;
				kept_box[i] = '0;
			end
			model_empty = 1'b1;
			kept_ok = 1'b0;
			box_answers.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tabb_pkg::CFG_ROW_X:   coef_row[0] = cfg_data;
					tabb_pkg::CFG_ROW_Y:   coef_row[1] = cfg_data;
					tabb_pkg::CFG_ROW_Z:   coef_row[2] = cfg_data;
					tabb_pkg::CFG_SHIFT_X: offset[0] = cfg_data[31:0];
					tabb_pkg::CFG_SHIFT_Y: offset[1] = cfg_data[31:0];
					tabb_pkg::CFG_SHIFT_Z: offset[2] = cfg_data[31:0];
					default: ;
				endcase
			end

			if (result_valid && !result_stall) begin
				if (box_answers.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t unexpected result beat %h", $realtime, result);
				end else begin
					want = box_answers.pop_front();
					note_field("box_min_x", result.box_min_x, want.box_min_x);
					note_field("box_max_x", result.box_max_x, want.box_max_x);
					note_field("box_min_y", result.box_min_y, want.box_min_y);
					note_field("box_max_y", result.box_max_y, want.box_max_y);
					note_field("box_min_z", result.box_min_z, want.box_min_z);
					note_field("box_max_z", result.box_max_z, want.box_max_z);
					note_field("overlap", 32'(result.overlap), 32'(want.overlap));
					note_field("box_valid", 32'(result.box_valid), 32'(want.box_valid));
				end
			end

			if (item_valid && !item_stall) begin
				want.overlap = 1'b0;
				if (item.kind == tabb_pkg::KIND_VERTEX) begin
					for (int a = 0; a < tabb_pkg::AXES; a++) begin
						p = map_axis(a, item);
						if (model_empty || p < live_box[2*a])
							live_box[2*a] = p;
						if (model_empty || p > live_box[2*a+1])
							live_box[2*a+1] = p;
					end
					model_empty = 1'b0;
					if (item.last) begin
						kept_box = live_box;
						kept_ok = 1'b1;
						model_empty = 1'b1;
					end
				end else if (kept_ok) begin
					want.overlap =
						$signed(item.other_min_x) <= kept_box[1] &&
						$signed(item.other_max_x) >= kept_box[0] &&
						$signed(item.other_min_y) <= kept_box[3] &&
						$signed(item.other_max_y) >= kept_box[2] &&
						$signed(item.other_min_z) <= kept_box[5] &&
						$signed(item.other_max_z) >= kept_box[4];
				end
				if (item.kind == tabb_pkg::KIND_QUERY || item.last) begin
					want.box_min_x = kept_box[0];
					want.box_max_x = kept_box[1];
					want.box_min_y = kept_box[2];
					want.box_max_y = kept_box[3];
					want.box_min_z = kept_box[4];
					want.box_max_z = kept_box[5];
					want.box_valid = kept_ok;
					box_answers.push_back(want);
				end
			end
			pending = box_answers.size();
		end
	end

endmodule

### test/tb_top.sv
// Testbench top for the bounding box builder: stimulus, register writes and verdict.
module tb_top;

	localparam logic [tabb_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [tabb_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
	localparam logic signed [31:0] MIN32 = 32'sh80000000;
	localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
	localparam int LIMIT = 200000;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	tabb_pkg::item_t                item;
	logic                           result_valid;
	logic                           result_stall;
	tabb_pkg::result_t              result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tabb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tabb_pkg::ROW_W-1:0]     cfg_data;
	int                             errors;
	int                             pending;
	int                             cycles;
	logic                           calm;

	transformed_aabb_builder_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	tabb_box_checker u_box_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic tabb_pkg::item_t scramble();
		logic [255:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		return bits[$bits(tabb_pkg::item_t)-1:0];
	endfunction

	function automatic tabb_pkg::item_t vtx(logic signed [15:0] x, y, z, logic last);
		tabb_pkg::item_t it;
		it = scramble();
		it.kind = tabb_pkg::KIND_VERTEX;
		it.vertex_x = x;
		it.vertex_y = y;
		it.vertex_z = z;
		it.last = last;
		return it;
	endfunction

	function automatic tabb_pkg::item_t qry(logic signed [31:0] lx, hx, ly, hy, lz, hz);
		tabb_pkg::item_t it;
		it = scramble();
		it.kind = tabb_pkg::KIND_QUERY;
		it.other_min_x = lx;
		it.other_max_x = hx;
		it.other_min_y = ly;
		it.other_max_y = hy;
		it.other_min_z = lz;
		it.other_max_z = hz;
		return it;
	endfunction

	function automatic logic signed [31:0] pick_bound();
		case ($urandom_range(0, 7))
			0: return MIN32;
			1: return MAX32;
			2: return $urandom;
			default: return int'($urandom_range(0, 32'h200000)) - 32'sh100000;
		endcase
	endfunction

	task automatic send(tabb_pkg::item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic write_reg(logic [tabb_pkg::CFG_IDX_W-1:0] idx, logic [tabb_pkg::ROW_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// hold the sender until every result is back and the pipeline is empty
	task automatic settle();
		@(negedge clk) item_valid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int hold;
		result_stall = 1'b0;
		wait (arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				@(negedge clk) result_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	initial begin
		logic [tabb_pkg::ROW_W-1:0] row;
		logic signed [31:0] b [6];
		logic signed [31:0] t;
		int budget;
		int len;
		int sent;
		bit open_end;
		bit paused;
		arst_n = 1'b0;
		calm = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// identity transform: box bounds equal the raw vertex values
		send(qry(MIN32, MAX32, MIN32, MAX32, MIN32, MAX32));
		send(vtx(16'sh7fff, 16'sh8000, 16'sh0101, 1'b1));
		send(qry(MIN32, MAX32, MIN32, MAX32, MIN32, MAX32));
		send(qry(32'sd32768, MAX32, MIN32, MAX32, MIN32, MAX32));
		send(qry(MAX32, MIN32, MAX32, MIN32, MAX32, MIN32));
		send(vtx(16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
		send(vtx(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
		send(qry(MIN32, MAX32, MIN32, MAX32, MIN32, MAX32));
		send(vtx(16'sh0000, 16'sh0000, 16'sh0000, 1'b1));
		send(qry(32'sd32767, 32'sd32767, -32'sd32768, -32'sd32768, MIN32, MAX32));
		send(qry(32'sd32768, MAX32, MIN32, MAX32, MIN32, MAX32));
		send(qry(MIN32, MAX32, MIN32, -32'sd32769, MIN32, MAX32));
		settle();

		write_reg(tabb_pkg::CFG_ROW_X, 48'h8000_8000_8000);
		write_reg(tabb_pkg::CFG_ROW_Y, 48'h8000_8000_8000);
		write_reg(tabb_pkg::CFG_ROW_Z, 48'hffff_ffff_ffff);
		write_reg(tabb_pkg::CFG_SHIFT_X, {16'h0000, MAX32});
		write_reg(tabb_pkg::CFG_SHIFT_Y, {16'hffff, MIN32});
		write_reg(tabb_pkg::CFG_SHIFT_Z, 48'hffff_0000_0000);
		write_reg(CFG_SPARE_6, {16'($urandom), $urandom});
		write_reg(CFG_SPARE_7, {16'($urandom), $urandom});
		send(vtx(16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
		send(vtx(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1));
		send(qry(MIN32, MAX32, MIN32, MAX32, MIN32, MAX32));
		settle();

		write_reg(tabb_pkg::CFG_ROW_X, 48'h7fff_7fff_7fff);
		write_reg(tabb_pkg::CFG_ROW_Y, 48'h7fff_7fff_7fff);
		write_reg(tabb_pkg::CFG_ROW_Z, 48'h0000_0000_0000);
		write_reg(tabb_pkg::CFG_SHIFT_X, {16'hffff, MIN32});
		write_reg(tabb_pkg::CFG_SHIFT_Y, {16'h0000, MAX32});
		write_reg(tabb_pkg::CFG_SHIFT_Z, 48'h0000_ffff_ffff);
		send(vtx(16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
		send(vtx(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1));
		send(qry(MIN32, MAX32, MIN32, MAX32, MIN32, MAX32));
		settle();

		sent = 0;
		while (sent < 500) begin
			for (int r = 0; r < tabb_pkg::AXES; r++) begin
				case ($urandom_range(0, 4))
					0: row = {16'($urandom), $urandom};
					1: begin
						for (int k = 0; k < 3; k++)
							row[16*k +: 16] = 16'($urandom_range(0, 8192) - 4096);
					end
					2: row = $urandom_range(0, 1) ? 48'h8000_8000_8000 : 48'h7fff_7fff_7fff;
					default: row = 48'h1000 << (16 * r);
				endcase
				write_reg(tabb_pkg::cfg_reg_t'(r), row);
			end
			for (int s = 0; s < tabb_pkg::AXES; s++) begin
				case ($urandom_range(0, 5))
					0: t = MAX32;
					1: t = MIN32;
					default: t = int'($urandom_range(0, 131072)) - 65536;
				endcase
				write_reg(tabb_pkg::cfg_reg_t'(tabb_pkg::CFG_SHIFT_X + s), {16'($urandom), t});
			end
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
					{16'($urandom), $urandom});
			calm = ($urandom_range(0, 3) == 0);
			paused = 1'b0;
			budget = 100;
			while (budget > 0) begin
				len = $urandom_range(1, 6);
				open_end = ($urandom_range(0, 9) == 0);
				for (int v = 0; v < len; v++) begin
					if ($urandom_range(0, 3) == 0) begin
						for (int i = 0; i < 6; i++)
							b[i] = pick_bound();
						for (int a = 0; a < 3; a++) begin
							if (b[2*a] > b[2*a+1] && $urandom_range(0, 5) != 0) begin
								t = b[2*a];
								b[2*a] = b[2*a+1];
								b[2*a+1] = t;
							end
						end
						send(qry(b[0], b[1], b[2], b[3], b[4], b[5]));
						budget--;
					end
					send(vtx(16'($urandom), 16'($urandom), 16'($urandom),
						v == len - 1 && !open_end));
					budget--;
				end
				if (!paused && budget < 50) begin
					settle();
					paused = 1'b1;
				end
			end
			sent += 100 - budget;
			calm = 1'b0;
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

### sim.f
hw/rtl/tabb_pkg.sv
hw/rtl/tabb_front.sv
hw/rtl/tabb_queue.sv
hw/rtl/tabb_back.sv
hw/rtl/transformed_aabb_builder_unit.sv
test/tabb_box_checker.sv
test/tb_top.sv
